// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/lbis_pkg.sv =====
// ----------------------------------------------------------------------------
// lbis_pkg
// shared types and constants of the led / buzzer indicator sequencer
// ----------------------------------------------------------------------------
package lbis_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_UPDATE   = 2'd0,
        CMD_SET_MODE = 2'd1,
        CMD_ALARM    = 2'd2,
        CMD_PULSE    = 2'd3
    } command_t;

    // indicator modes, codes above MODE_ERROR render the led off
    localparam logic [2:0] MODE_BOOTING    = 3'd0;
    localparam logic [2:0] MODE_CONNECTING = 3'd1;
    localparam logic [2:0] MODE_ONLINE     = 3'd2;
    localparam logic [2:0] MODE_WARNING    = 3'd3;
    localparam logic [2:0] MODE_ERROR      = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_LED_ENABLE         = 2'd0;
    localparam logic [1:0] CFG_BUZZER_ENABLE      = 2'd1;
    localparam logic [1:0] CFG_BUZZER_ACTIVE_HIGH = 2'd2;

    // timing constants in ms
    localparam logic [31:0] ALARM_GAP_MS      = 32'd150;
    localparam logic [31:0] FRAME_MS          = 32'd900;
    localparam logic [9:0]  FLASH_ONE_END     = 10'd100;
    localparam logic [9:0]  FLASH_TWO_START   = 10'd200;
    localparam logic [9:0]  FLASH_TWO_END     = 10'd300;

    // reciprocals: x / 125 = (x * DIV125_MAGIC) >> 35 for any 32-bit x,
    // x / 225 = (x * DIV225_MAGIC) >> 38 for any 30-bit x
    localparam logic [28:0] DIV125_MAGIC = 29'h10624DD3;
    localparam int          DIV125_SHIFT = 35;
    localparam logic [30:0] DIV225_MAGIC = 31'h48D159E3;
    localparam int          DIV225_SHIFT = 38;
    localparam int          FRAME_Q_W    = 23;

    // one command as it moves down the pipeline
    typedef struct packed {
        command_t    command;
        logic [31:0] now_ms;
        logic [2:0]  indicator_mode;
        logic [7:0]  alarm_cycles;
        logic [31:0] pulse_length_ms;
    } item_t;

    // led pattern levels for every mode that depends on time
    typedef struct packed {
        logic blink_500;
        logic blink_250;
        logic blink_125;
        logic double_flash;
    } pattern_t;

endpackage

// ===== rtl/core/lbis_pattern.sv =====
// ----------------------------------------------------------------------------
// lbis_pattern
// front pipeline: input register, reciprocal multiplies, frame phase; gives
// each command together with the led levels of all blink patterns
// ----------------------------------------------------------------------------
module lbis_pattern
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_stall,
    input  lbis_pkg::item_t    up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output lbis_pkg::item_t    dn_item,
    output lbis_pkg::pattern_t dn_pattern
);

    logic                              s0_valid_reg;
    lbis_pkg::item_t                   s0_item_reg;
    logic                              s1_valid_reg;
    lbis_pkg::item_t                   s1_item_reg;
    logic [2:0]                        s1_parity_reg;
    logic [lbis_pkg::FRAME_Q_W-1:0]    s1_frame_q_reg;
    logic                              s2_valid_reg;
    lbis_pkg::item_t                   s2_item_reg;
    lbis_pkg::pattern_t                s2_pattern_reg;

    logic        adv0;
    logic        adv1;
    logic        adv2;
    logic [60:0] prod_125;
    logic [60:0] prod_250;
    logic [60:0] prod_500;
    logic [60:0] prod_900;
    logic [31:0] frame_rem;
    logic [9:0]  phase;
    lbis_pkg::pattern_t pattern_next;

    // stage advance, each stage moves when empty or when its successor moves
    assign adv2     = !s2_valid_reg || dn_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign adv0     = !s0_valid_reg || adv1;
    assign up_stall = !adv0;

    // quotient parity by 125 of now, now/2 and now/4, and now/900
    assign prod_125 = 61'(s0_item_reg.now_ms) * 61'(lbis_pkg::DIV125_MAGIC);
    assign prod_250 = 61'(s0_item_reg.now_ms[31:1]) * 61'(lbis_pkg::DIV125_MAGIC);
    assign prod_500 = 61'(s0_item_reg.now_ms[31:2]) * 61'(lbis_pkg::DIV125_MAGIC);
    assign prod_900 = 61'(s0_item_reg.now_ms[31:2]) * 61'(lbis_pkg::DIV225_MAGIC);

    // phase inside the double flash frame
    assign frame_rem = s1_item_reg.now_ms - 32'(s1_frame_q_reg) * lbis_pkg::FRAME_MS;
    assign phase     = frame_rem[9:0];

    always_comb
    begin
        pattern_next.blink_125    = !s1_parity_reg[0];
        pattern_next.blink_250    = !s1_parity_reg[1];
        pattern_next.blink_500    = !s1_parity_reg[2];
        pattern_next.double_flash = (phase < lbis_pkg::FLASH_ONE_END) ||
                                    ((phase >= lbis_pkg::FLASH_TWO_START) &&
                                     (phase < lbis_pkg::FLASH_TWO_END));
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                s0_valid_reg <= up_valid;
            end
            if (adv1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            s0_item_reg <= up_item;
        end
        if (adv1)
        begin
            s1_item_reg    <= s0_item_reg;
            s1_parity_reg  <= {prod_500[lbis_pkg::DIV125_SHIFT],
                               prod_250[lbis_pkg::DIV125_SHIFT],
                               prod_125[lbis_pkg::DIV125_SHIFT]};
            s1_frame_q_reg <= prod_900[lbis_pkg::DIV225_SHIFT +: lbis_pkg::FRAME_Q_W];
        end
        if (adv2)
        begin
            s2_item_reg    <= s1_item_reg;
            s2_pattern_reg <= pattern_next;
        end
    end

    assign dn_valid   = s2_valid_reg;
    assign dn_item    = s2_item_reg;
    assign dn_pattern = s2_pattern_reg;

endmodule

// ===== rtl/core/led_buzzer_indicator_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_buzzer_indicator_sequencer
// led and buzzer indicator: alarm toggling, buzzer pulses and led blink modes
// ----------------------------------------------------------------------------
// Takes one command per clock while in_stall is low and returns one result
// per command. The four register stages are the input register, the
// reciprocal multiplies that split the millisecond time into blink periods,
// the 900 ms frame phase, and the state update that loads the result
// register. State changes only at that last stage, in command order.
// Configuration writes are always taken (cfg_ready is tied high) and should
// be made while no command is in flight.
module led_buzzer_indicator_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] now_ms,
    input  logic [2:0]  indicator_mode,
    input  logic [7:0]  alarm_cycles,
    input  logic [31:0] pulse_length_ms,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        led_level,
    output logic        buzzer_level,
    output logic        alarm_busy,
    output logic        pulse_busy,
    output logic        trigger_rejected,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);

    `include "assert_macros.svh"

    lbis_pkg::item_t    up_item;
    logic               pl_valid;
    logic               pl_ready;
    lbis_pkg::item_t    pl_item;
    lbis_pkg::pattern_t pl_pattern;

    // configuration
    logic        led_enable_reg;
    logic        buzzer_enable_reg;
    logic        buzzer_active_high_reg;

    // sequencer state
    logic [2:0]  mode_reg;
    logic        led_on_reg;
    logic        buzzer_on_reg;
    logic [8:0]  toggles_left_reg;
    logic [31:0] last_toggle_time_reg;
    logic        alarm_flag_reg;
    logic        pulse_flag_reg;
    logic [31:0] pulse_start_time_reg;
    logic [31:0] pulse_length_reg;

    logic [2:0]  mode_next;
    logic        led_on_next;
    logic        buzzer_on_next;
    logic [8:0]  toggles_left_next;
    logic [31:0] last_toggle_time_next;
    logic        alarm_flag_next;
    logic        pulse_flag_next;
    logic [31:0] pulse_start_time_next;
    logic [31:0] pulse_length_next;
    logic        rejected_next;

    // result register
    logic        out_valid_reg;
    logic        led_level_reg;
    logic        buzzer_level_reg;
    logic        alarm_busy_reg;
    logic        pulse_busy_reg;
    logic        trigger_rejected_reg;

    logic        out_load;
    logic        consume;
    logic        cfg_fire;
    logic        pattern_level;
    logic [31:0] toggle_elapsed;
    logic [31:0] pulse_elapsed;

    assign up_item.command         = lbis_pkg::command_t'(command);
    assign up_item.now_ms          = now_ms;
    assign up_item.indicator_mode  = indicator_mode;
    assign up_item.alarm_cycles    = alarm_cycles;
    assign up_item.pulse_length_ms = pulse_length_ms;

    lbis_pattern u_pattern
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_stall   (in_stall),
        .up_item    (up_item),
        .dn_valid   (pl_valid),
        .dn_ready   (pl_ready),
        .dn_item    (pl_item),
        .dn_pattern (pl_pattern)
    );

    // result register loads when empty or being taken
    assign out_load  = !out_valid_reg || !out_stall;
    assign pl_ready  = out_load;
    assign consume   = pl_valid && out_load;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // led level of the current mode
    always_comb
    begin
        case (mode_reg)
            lbis_pkg::MODE_BOOTING:    pattern_level = pl_pattern.blink_500;
            lbis_pkg::MODE_CONNECTING: pattern_level = pl_pattern.blink_250;
            lbis_pkg::MODE_ONLINE:     pattern_level = 1'b1;
            lbis_pkg::MODE_WARNING:    pattern_level = pl_pattern.blink_125;
            lbis_pkg::MODE_ERROR:      pattern_level = pl_pattern.double_flash;
            default:                   pattern_level = 1'b0;
        endcase
    end

    assign toggle_elapsed = pl_item.now_ms - last_toggle_time_reg;
    assign pulse_elapsed  = pl_item.now_ms - pulse_start_time_reg;

    // state update for one command
    always_comb
    begin
        mode_next             = mode_reg;
        led_on_next           = led_on_reg;
        buzzer_on_next        = buzzer_on_reg;
        toggles_left_next     = toggles_left_reg;
        last_toggle_time_next = last_toggle_time_reg;
        alarm_flag_next       = alarm_flag_reg;
        pulse_flag_next       = pulse_flag_reg;
        pulse_start_time_next = pulse_start_time_reg;
        pulse_length_next     = pulse_length_reg;
        rejected_next         = 1'b0;
        case (pl_item.command)
            lbis_pkg::CMD_UPDATE:
            begin
                if (!led_enable_reg && !buzzer_enable_reg)
                begin
                    // both outputs disabled, nothing moves
                end
                else if (toggles_left_reg != 9'd0)
                begin
                    // alarm toggling, zero time stamp means not yet started
                    if ((last_toggle_time_reg == 32'd0) ||
                        (toggle_elapsed >= lbis_pkg::ALARM_GAP_MS))
                    begin
                        last_toggle_time_next = pl_item.now_ms;
                        led_on_next           = led_enable_reg && !led_on_reg;
                        buzzer_on_next        = buzzer_enable_reg && !buzzer_on_reg;
                        toggles_left_next     = toggles_left_reg - 9'd1;
                        if ((toggles_left_reg == 9'd1) && alarm_flag_reg)
                        begin
                            alarm_flag_next = 1'b0;
                            buzzer_on_next  = 1'b0;
                        end
                    end
                end
                else if (pulse_flag_reg && (pulse_start_time_reg == 32'd0))
                begin
                    // pulse begins at this time stamp
                    pulse_start_time_next = pl_item.now_ms;
                    buzzer_on_next        = buzzer_enable_reg;
                end
                else if (pulse_flag_reg && (pulse_elapsed < pulse_length_reg))
                begin
                    buzzer_on_next = buzzer_enable_reg;
                end
                else
                begin
                    // pulse over or idle, led follows the mode pattern
                    pulse_flag_next       = 1'b0;
                    pulse_start_time_next = pulse_flag_reg ? 32'd0 : pulse_start_time_reg;
                    pulse_length_next     = pulse_flag_reg ? 32'd0 : pulse_length_reg;
                    led_on_next           = led_enable_reg && pattern_level;
                    buzzer_on_next        = 1'b0;
                end
            end
            lbis_pkg::CMD_SET_MODE:
            begin
                mode_next = pl_item.indicator_mode;
            end
            lbis_pkg::CMD_ALARM:
            begin
                if ((pl_item.alarm_cycles == 8'd0) || !buzzer_enable_reg)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    toggles_left_next     = {pl_item.alarm_cycles, 1'b0};
                    last_toggle_time_next = 32'd0;
                    alarm_flag_next       = 1'b1;
                    pulse_flag_next       = 1'b0;
                    pulse_start_time_next = 32'd0;
                    pulse_length_next     = 32'd0;
                end
            end
            lbis_pkg::CMD_PULSE:
            begin
                if ((pl_item.pulse_length_ms == 32'd0) || !buzzer_enable_reg)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    pulse_flag_next       = 1'b1;
                    pulse_start_time_next = 32'd0;
                    pulse_length_next     = pl_item.pulse_length_ms;
                end
            end
            default:
            begin
                rejected_next = 1'b0;
            end
        endcase
    end

    // configuration and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_enable_reg         <= 1'b0;
            buzzer_enable_reg      <= 1'b0;
            buzzer_active_high_reg <= 1'b1;
            mode_reg               <= lbis_pkg::MODE_BOOTING;
            led_on_reg             <= 1'b0;
            buzzer_on_reg          <= 1'b0;
            toggles_left_reg       <= 9'd0;
            last_toggle_time_reg   <= 32'd0;
            alarm_flag_reg         <= 1'b0;
            pulse_flag_reg         <= 1'b0;
            pulse_start_time_reg   <= 32'd0;
            pulse_length_reg       <= 32'd0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                lbis_pkg::CFG_LED_ENABLE:
                begin
                    led_enable_reg <= cfg_data;
                    if (!cfg_data)
                    begin
                        led_on_reg <= 1'b0;
                    end
                end
                lbis_pkg::CFG_BUZZER_ENABLE:
                begin
                    buzzer_enable_reg <= cfg_data;
                    if (!cfg_data)
                    begin
                        buzzer_on_reg <= 1'b0;
                    end
                end
                lbis_pkg::CFG_BUZZER_ACTIVE_HIGH:
                begin
                    buzzer_active_high_reg <= cfg_data;
                end
                default:
                begin
                    // unused index, write ignored
                end
            endcase
        end
        else if (consume)
        begin
            mode_reg             <= mode_next;
            led_on_reg           <= led_on_next;
            buzzer_on_reg        <= buzzer_on_next;
            toggles_left_reg     <= toggles_left_next;
            last_toggle_time_reg <= last_toggle_time_next;
            alarm_flag_reg       <= alarm_flag_next;
            pulse_flag_reg       <= pulse_flag_next;
            pulse_start_time_reg <= pulse_start_time_next;
            pulse_length_reg     <= pulse_length_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= pl_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            led_level_reg        <= led_on_next;
            buzzer_level_reg     <= buzzer_on_next ^ !buzzer_active_high_reg;
            alarm_busy_reg       <= (toggles_left_next != 9'd0);
            pulse_busy_reg       <= pulse_flag_next;
            trigger_rejected_reg <= rejected_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign led_level        = led_level_reg;
    assign buzzer_level     = buzzer_level_reg;
    assign alarm_busy       = alarm_busy_reg;
    assign pulse_busy       = pulse_busy_reg;
    assign trigger_rejected = trigger_rejected_reg;

    // state invariants
    `ASSERT_IMPLIES(a_alarm_has_toggles, alarm_flag_reg, toggles_left_reg != 9'd0)
    `ASSERT_IMPLIES(a_led_held_off, !led_enable_reg, !led_on_reg)
    `ASSERT_IMPLIES(a_buzzer_held_off, !buzzer_enable_reg, !buzzer_on_reg)
    `ASSERT_IMPLIES(a_idle_pulse_clear, !pulse_flag_reg, pulse_start_time_reg == 32'd0)

endmodule
